// ----- rtl/core/fqfl_pkg.sv -----
// Shared types, constants and helpers for the queue with frequency lookup.
// Depends on nothing; every module of the block but fqfl_ram imports it.
package fqfl_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int VALUE_W     = 32;
	localparam int FREQ_W      = 16;
	localparam int ENTRY_W     = VALUE_W + FREQ_W;

	localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};

	// Commands
	localparam logic [1:0] CMD_PUSH      = 2'd0;
	localparam logic [1:0] CMD_POP       = 2'd1;
	localparam logic [1:0] CMD_LOOKUP    = 2'd2;
	localparam logic [1:0] CMD_INCREMENT = 2'd3;

	// Result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EMPTY     = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic [1:0]               command;
		logic signed [VALUE_W-1:0] key_value;
		logic [FREQ_W-1:0]        push_frequency;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic                     found;
		logic signed [VALUE_W-1:0] out_value;
		logic [FREQ_W-1:0]        out_frequency;
		logic                     queue_empty;
	} res_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic push_wr;
		logic push_full;
		logic pop_empty;
		logic pop_rd;
		logic pop_take;
		logic scan_init;
		logic scan_step;
		logic fin;
	} dp_ctrl_t;

	// Datapath to controller status
	typedef struct packed {
		logic [1:0] cmd;
		logic       empty;
		logic       full;
		logic       scan_done;
	} dp_stat_t;

	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] nxt;
		if (idx == IDX_W'(QUEUE_DEPTH - 1))
			nxt = '0;
		else
			nxt = idx + IDX_W'(1);
		return nxt;
	endfunction

endpackage

// ----- rtl/core/fifo_queue_with_frequency_lookup_unit.sv -----
// Top level of the bounded queue with frequency lookup.
// Depends on fqfl_pkg, fqfl_ctrl and fqfl_datapath (which holds fqfl_ram).
//
// A command beat is taken on a rising edge with start high and busy low; busy
// stays high until the command's result has been registered. The result beat
// sits on result for one cycle with done high and cannot be held off, so the
// receiver must take it then. A push and a pop of an empty queue pass through
// decode and finish only; any other pop also reads the head entry, and a lookup
// or increment scans the queued entries from the head, reading one entry per
// cycle through the single read port of the entry RAM, which has a registered
// read; a lookup stops at its first match from the head.
// No clearing pass after reset: entries are only read once written.
module fifo_queue_with_frequency_lookup_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  fqfl_pkg::req_t request,
	output logic           busy,
	output logic           done,
	output fqfl_pkg::res_t result
);
	import fqfl_pkg::*;

	dp_ctrl_t ctl;
	dp_stat_t stat;

	// Sequence each command: decode, access the RAM where needed, then finish
	fqfl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	// Hold entries and pointers, run the scan, register the result beat
	fqfl_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.ctl     (ctl),
		.stat    (stat),
		.result  (result)
	);

endmodule

// ----- rtl/core/fqfl_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package needed.
module fqfl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/fqfl_datapath.sv -----
// Datapath: entry RAM, head/tail/count pointers, scan pipeline and result register.
// Depends on fqfl_pkg and fqfl_ram.
module fqfl_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  fqfl_pkg::req_t    request,
	input  fqfl_pkg::dp_ctrl_t ctl,
	output fqfl_pkg::dp_stat_t stat,
	output fqfl_pkg::res_t    result
);
	import fqfl_pkg::*;

	logic [IDX_W-1:0]   head_q, tail_q, rd_idx_q, addr_s1;
	logic [CNT_W-1:0]   count_q, issued_q, checked_q;
	logic               stop_q, rvalid_s1;
	logic [1:0]         cmd_q;
	logic [VALUE_W-1:0] key_q;
	logic [FREQ_W-1:0]  pfreq_q;
	logic [1:0]         wk_status_q;
	logic               wk_found_q;
	logic [VALUE_W-1:0] wk_value_q;
	logic [FREQ_W-1:0]  wk_freq_q;
	res_t               result_q;

	logic               ram_we, ram_re;
	logic [IDX_W-1:0]   ram_waddr, ram_raddr;
	logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
	logic [VALUE_W-1:0] rd_value;
	logic [FREQ_W-1:0]  rd_freq, inc_freq;
	logic               issue_go, check_go, hit;

	assign rd_value = ram_rdata[ENTRY_W-1:FREQ_W];
	assign rd_freq  = ram_rdata[FREQ_W-1:0];
	assign inc_freq = (rd_freq == FREQ_MAX) ? rd_freq : rd_freq + FREQ_W'(1);

	assign issue_go = ctl.scan_step && (issued_q != count_q) && !stop_q;
	assign check_go = ctl.scan_step && rvalid_s1 && !stop_q;
	assign hit      = check_go && (rd_value == key_q);

	assign ram_re    = ctl.pop_rd || issue_go;
	assign ram_raddr = ctl.pop_rd ? head_q : rd_idx_q;
	assign ram_we    = ctl.push_wr || (hit && cmd_q == CMD_INCREMENT);
	assign ram_waddr = ctl.push_wr ? tail_q : addr_s1;
	assign ram_wdata = ctl.push_wr ? {key_q, pfreq_q} : {rd_value, inc_freq};

	fqfl_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_entries (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Pointers and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			rd_idx_q  <= '0;
			issued_q  <= '0;
			checked_q <= '0;
			stop_q    <= 1'b0;
			rvalid_s1 <= 1'b0;
		end else begin
			if (ctl.push_wr) begin
				tail_q  <= next_idx(tail_q);
				count_q <= count_q + CNT_W'(1);
			end
			if (ctl.pop_take) begin
				head_q  <= next_idx(head_q);
				count_q <= count_q - CNT_W'(1);
			end
			if (ctl.scan_init) begin
				rd_idx_q  <= head_q;
				issued_q  <= '0;
				checked_q <= '0;
				stop_q    <= 1'b0;
				rvalid_s1 <= 1'b0;
			end else if (ctl.scan_step) begin
				rvalid_s1 <= issue_go;
				if (issue_go) begin
					rd_idx_q <= next_idx(rd_idx_q);
					issued_q <= issued_q + CNT_W'(1);
				end
				if (check_go)
					checked_q <= checked_q + CNT_W'(1);
				if (hit && cmd_q == CMD_LOOKUP)
					stop_q <= 1'b1;
			end
		end
	end

	// Payload and working result
	always_ff @(posedge clk) begin
		if (issue_go)
			addr_s1 <= rd_idx_q;
		if (ctl.load) begin
			cmd_q       <= request.command;
			key_q       <= request.key_value;
			pfreq_q     <= request.push_frequency;
			wk_status_q <= ST_OK;
			wk_found_q  <= 1'b0;
			wk_value_q  <= request.key_value;
			wk_freq_q   <= '0;
		end
		if (ctl.push_full)
			wk_status_q <= ST_FULL;
		if (ctl.pop_empty)
			wk_status_q <= ST_EMPTY;
		if (ctl.pop_take) begin
			wk_value_q <= rd_value;
			wk_freq_q  <= rd_freq;
			wk_found_q <= 1'b1;
		end
		if (ctl.scan_init)
			wk_status_q <= ST_NOT_FOUND;
		if (hit) begin
			wk_status_q <= ST_OK;
			wk_found_q  <= 1'b1;
			if (cmd_q == CMD_LOOKUP)
				wk_freq_q <= rd_freq;
		end
		if (ctl.fin) begin
			result_q.status        <= wk_status_q;
			result_q.found         <= wk_found_q;
			result_q.out_value     <= $signed(wk_value_q);
			result_q.out_frequency <= wk_freq_q;
			result_q.queue_empty   <= (count_q == '0);
		end
	end

	assign stat.cmd       = cmd_q;
	assign stat.empty     = (count_q == '0);
	assign stat.full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign stat.scan_done = (checked_q == count_q) || stop_q;
	assign result         = result_q;

endmodule

// ----- rtl/core/fqfl_ctrl.sv -----
// Controller: sequences one command at a time through decode, pop read, scan and finish.
// Depends on fqfl_pkg.
module fqfl_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  fqfl_pkg::dp_stat_t stat,
	output fqfl_pkg::dp_ctrl_t ctl,
	output logic               busy,
	output logic               done
);
	import fqfl_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_POP    = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_FIN    = 3'd4;

	logic [2:0] state_q, state_d;
	logic       done_q;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				case (stat.cmd)
					CMD_PUSH: begin
						if (stat.full)
							ctl.push_full = 1'b1;
						else
							ctl.push_wr = 1'b1;
						state_d = S_FIN;
					end
					CMD_POP: begin
						if (stat.empty) begin
							ctl.pop_empty = 1'b1;
							state_d       = S_FIN;
						end else begin
							ctl.pop_rd = 1'b1;
							state_d    = S_POP;
						end
					end
					default: begin
						ctl.scan_init = 1'b1;
						state_d       = S_SCAN;
					end
				endcase
			end
			S_POP: begin
				ctl.pop_take = 1'b1;
				state_d      = S_FIN;
			end
			S_SCAN: begin
				if (stat.scan_done)
					state_d = S_FIN;
				else
					ctl.scan_step = 1'b1;
			end
			S_FIN: begin
				ctl.fin = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= ctl.fin;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule
